[rtl/ipd_pkg.sv]
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared types and constants of the isolated pixel detector.
// ----------------------------------------------------------------------------
package ipd_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;

  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int ROW_W    = 12;

  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int REG_SEL_BIT = 2;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd1024;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic sat;
    logic pix;
  } line_entry_t;

endpackage

[rtl/ipd_ram.sv]
// ----------------------------------------------------------------------------
// ipd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ipd_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/isolated_pixel_detector.sv]
// ----------------------------------------------------------------------------
// isolated_pixel_detector
// Checks a binary raster image for black pixels without a black 4-neighbour.
//
// Pixels enter on the in_ channel (valid/ready), one per transaction, in
// raster order; 1 is black. Frame size comes from the image_width and
// image_height registers on the APB port (byte addresses 0 and 4); a write
// restarts the frame. Pixels outside the frame count as white.
// On the last pixel of a frame one transaction leaves on the out_ channel:
// out_ok is 1 when no black pixel of the frame was isolated.
// Throughput is one pixel per clock while in_ready is high, set by the single
// write and single read port of the line store. The last pixel is registered
// in the check stage, and its result is then registered onto the out_ channel.
// Reset sets both dimensions to 1024 and clears counters and flags; the line
// store is not cleared, since each entry read was written in the row before.
// While a result waits, pixels are still accepted; only the last pixel of the
// next frame holds in the check stage, and in_ready drops, until out_ready.
// ----------------------------------------------------------------------------
module isolated_pixel_detector
  import ipd_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_pixel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ok,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
  localparam int WC_W   = (WEFF_W > WIDTH_W) ? WEFF_W : WIDTH_W;
  localparam logic [WC_W-1:0]     MAXW_C = WC_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] MAXH_C = HEIGHT_W'(MAX_HEIGHT);

  logic [WIDTH_W-1:0]  image_width_r, image_width_nxt;
  logic [HEIGHT_W-1:0] image_height_r, image_height_nxt;

  logic [COL_W-1:0] col_count_r, col_count_nxt;
  logic [ROW_W-1:0] row_count_r, row_count_nxt;

  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_pix_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_first_row_r, s1_last_row_r, s1_first_col_r, s1_last_col_r;

  logic             lw_pix_r, lw_pix_nxt, lw_sat_r, lw_sat_nxt;
  logic             fail_flag_r, fail_flag_nxt;

  logic             pend_valid_r, pend_valid_nxt;
  logic [COL_W-1:0] pend_addr_r;
  logic             pend_pix_r, pend_sat_r, pend_open_r;

  logic             byp_hit_r, byp_hit_nxt;
  line_entry_t      byp_data_r;

  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r;

  logic [WC_W-1:0]     width_ext, w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [COL_W-1:0]    last_col_idx;
  logic [ROW_W-1:0]    last_row_idx;
  logic                at_last_col, at_last_row;

  logic        cfg_wr, in_fire, s1_fire, s1_hold, frame_end;
  logic        pend_hit, up, us, lp, ls, sat, fail_now;
  line_entry_t up_e, ram_rdata, ram_wdata;
  logic        ram_we;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    case (reg_idx_t'(paddr[REG_SEL_BIT]))
      REG_IMAGE_WIDTH:  prdata = PDATA_W'(image_width_r);
      REG_IMAGE_HEIGHT: prdata = PDATA_W'(image_height_r);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    image_width_nxt  = image_width_r;
    image_height_nxt = image_height_r;
    if (cfg_wr) begin
      case (reg_idx_t'(paddr[REG_SEL_BIT]))
        REG_IMAGE_WIDTH:  image_width_nxt  = pwdata[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height_nxt = pwdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign width_ext = WC_W'(image_width_r);

  always_comb begin
    if (width_ext == '0) begin
      w_eff = WC_W'(1);
    end else if (width_ext > MAXW_C) begin
      w_eff = MAXW_C;
    end else begin
      w_eff = width_ext;
    end
    if (image_height_r == '0) begin
      h_eff = HEIGHT_W'(1);
    end else if (image_height_r > MAXH_C) begin
      h_eff = MAXH_C;
    end else begin
      h_eff = image_height_r;
    end
  end

  assign last_col_idx = COL_W'(w_eff - WC_W'(1));
  assign last_row_idx = ROW_W'(h_eff - HEIGHT_W'(1));
  assign at_last_col  = (col_count_r == last_col_idx);
  assign at_last_row  = (row_count_r == last_row_idx);

  // check stage
  assign frame_end = s1_last_row_r & s1_last_col_r;
  assign s1_hold   = s1_valid_r & frame_end & out_valid_r & ~out_ready;
  assign s1_fire   = s1_valid_r & ~s1_hold;
  assign in_ready  = ~s1_hold;
  assign in_fire   = in_valid & in_ready;

  assign pend_hit = pend_valid_r & (pend_addr_r == s1_col_r);

  always_comb begin
    if (pend_hit) begin
      up_e = '{sat: pend_sat_r, pix: pend_pix_r};
    end else if (byp_hit_r) begin
      up_e = byp_data_r;
    end else begin
      up_e = ram_rdata;
    end
  end

  assign up  = ~s1_first_row_r & up_e.pix;
  assign us  = up_e.sat;
  assign lp  = ~s1_first_col_r & lw_pix_r;
  assign ls  = lw_sat_r;
  assign sat = up | lp;

  assign fail_now = (up & ~(us | s1_pix_r))
                  | (s1_last_row_r & lp & ~(ls | s1_pix_r))
                  | (frame_end & s1_pix_r & ~sat);

  assign ram_we    = s1_fire & pend_valid_r;
  assign ram_wdata = '{sat: pend_sat_r | (pend_open_r & s1_pix_r), pix: pend_pix_r};

  ipd_ram #(
    .WIDTH ($bits(line_entry_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pend_addr_r),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (col_count_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    col_count_nxt  = col_count_r;
    row_count_nxt  = row_count_r;
    s1_valid_nxt   = s1_valid_r;
    lw_pix_nxt     = lw_pix_r;
    lw_sat_nxt     = lw_sat_r;
    fail_flag_nxt  = fail_flag_r;
    pend_valid_nxt = pend_valid_r;
    byp_hit_nxt    = byp_hit_r;
    out_valid_nxt  = out_valid_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_fire) begin
      s1_valid_nxt   = 1'b0;
      pend_valid_nxt = 1'b1;
      fail_flag_nxt  = frame_end ? 1'b0 : (fail_flag_r | fail_now);
      lw_pix_nxt     = s1_last_col_r ? 1'b0 : s1_pix_r;
      lw_sat_nxt     = s1_last_col_r ? 1'b0 : sat;
      if (frame_end) begin
        out_valid_nxt = 1'b1;
      end
    end
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
      byp_hit_nxt  = ram_we & (pend_addr_r == col_count_r);
      if (at_last_col) begin
        col_count_nxt = '0;
        row_count_nxt = at_last_row ? '0 : row_count_r + ROW_W'(1);
      end else begin
        col_count_nxt = col_count_r + COL_W'(1);
      end
    end
    if (cfg_wr) begin
      col_count_nxt  = '0;
      row_count_nxt  = '0;
      lw_pix_nxt     = 1'b0;
      lw_sat_nxt     = 1'b0;
      fail_flag_nxt  = 1'b0;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RST;
      image_height_r <= HEIGHT_RST;
      col_count_r    <= '0;
      row_count_r    <= '0;
      s1_valid_r     <= 1'b0;
      lw_pix_r       <= 1'b0;
      lw_sat_r       <= 1'b0;
      fail_flag_r    <= 1'b0;
      pend_valid_r   <= 1'b0;
      byp_hit_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      image_width_r  <= image_width_nxt;
      image_height_r <= image_height_nxt;
      col_count_r    <= col_count_nxt;
      row_count_r    <= row_count_nxt;
      s1_valid_r     <= s1_valid_nxt;
      lw_pix_r       <= lw_pix_nxt;
      lw_sat_r       <= lw_sat_nxt;
      fail_flag_r    <= fail_flag_nxt;
      pend_valid_r   <= pend_valid_nxt;
      byp_hit_r      <= byp_hit_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r       <= in_pixel;
      s1_col_r       <= col_count_r;
      s1_first_row_r <= (row_count_r == '0);
      s1_last_row_r  <= at_last_row;
      s1_first_col_r <= (col_count_r == '0);
      s1_last_col_r  <= at_last_col;
      byp_data_r     <= ram_wdata;
    end
    if (s1_fire) begin
      pend_addr_r <= s1_col_r;
      pend_pix_r  <= s1_pix_r;
      pend_sat_r  <= sat;
      pend_open_r <= ~s1_last_col_r;
      if (frame_end) begin
        out_ok_r <= ~(fail_flag_r | fail_now);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;

endmodule

[rtl/ipd_checker.sv]
// ----------------------------------------------------------------------------
// ipd_checker
// Port-level checks of the isolated pixel detector, bound to the top level.
// ----------------------------------------------------------------------------
module ipd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_ok
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok))
    else $error("stalled result transaction changed or dropped");

  // back-pressure only while a result waits
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

  // a new result is preceded by an accepted pixel
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result transaction without a preceding pixel");

endmodule

bind isolated_pixel_detector ipd_checker u_ipd_checker (.*);

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the isolated pixel detector.
//
// Binary frames are queued for a valid/ready driver and predicted pixel by
// pixel at acceptance. A monitor compares each out_ok transaction with the
// oldest predicted frame verdict. Frame size is reprogrammed over APB between
// phases: out-of-range sizes, one-pixel-wide and one-pixel-high frames, a
// truncated frame at the reset size and one frame at the largest width.
// Half of the random frames are cleaned of isolated pixels so both verdicts
// occur. Both sides idle at random, and the receiver once holds off long
// enough to stall the input.
// ----------------------------------------------------------------------------
module testbench;
  import ipd_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_pixel = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_ok;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  isolated_pixel_detector DUT (
    .clk, .rst_n, .in_valid, .in_ready, .in_pixel, .out_valid, .out_ready,
    .out_ok, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // frame geometry and scan state as the block should hold them
  logic [WIDTH_W-1:0]  cfg_width;
  logic [HEIGHT_W-1:0] cfg_height;
  line_entry_t         above_row [MAX_WIDTH_DEF];
  int unsigned         row_idx;
  int unsigned         col_idx;
  line_entry_t         left_px;
  bit                  frame_bad;

  logic        pending_pixels [$];
  logic        expected_ok [$];
  int unsigned pix_gap = 0;
  int unsigned pix_gap_max = 0;
  int unsigned ok_stall_max = 0;
  int unsigned stall_left = 0;
  int          holds_asked = 0;
  int          holds_served = 0;
  int unsigned queued = 0;
  int unsigned pixels_sent = 0;
  int unsigned frames_done = 0;
  int unsigned bad_frames = 0;
  int unsigned results_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned errors = 0;
  logic        want_ok;

  function automatic int unsigned span_cols();
    if (cfg_width == 0) return 1;
    if (cfg_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return cfg_width;
  endfunction

  function automatic int unsigned span_rows();
    if (cfg_height == 0) return 1;
    if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
    return cfg_height;
  endfunction

  function automatic void restart_frame_model();
    row_idx = 0;
    col_idx = 0;
    left_px = '0;
    frame_bad = 1'b0;
  endfunction

  function automatic void scan_pixel(input logic pix);
    int unsigned w, h, c;
    bit          at_last_row, at_last_col;
    line_entry_t up_e;
    logic        up_pix, left_pix, has_nb;
    w = span_cols();
    h = span_rows();
    c = col_idx;
    at_last_row = (row_idx + 1 >= h);
    at_last_col = (c + 1 >= w);
    up_pix = 1'b0;
    left_pix = 1'b0;
    if (row_idx != 0) begin
      up_e = above_row[c];
      up_pix = up_e.pix;
      if (up_e.pix && !(up_e.sat || pix)) frame_bad = 1'b1;
    end
    if (c != 0) begin
      left_pix = left_px.pix;
      if (pix) above_row[c-1].sat = 1'b1;
      if (at_last_row && left_px.pix && !(left_px.sat || pix)) frame_bad = 1'b1;
    end
    has_nb = up_pix | left_pix;
    above_row[c] = '{sat: has_nb, pix: pix};
    if (at_last_row && at_last_col && pix && !has_nb) frame_bad = 1'b1;
    if (at_last_col) begin
      left_px = '0;
      col_idx = 0;
      if (at_last_row) begin
        expected_ok.push_back(!frame_bad);
        frames_done++;
        if (frame_bad) bad_frames++;
        restart_frame_model();
      end else begin
        row_idx = row_idx + 1;
      end
    end else begin
      left_px = '{sat: has_nb, pix: pix};
      col_idx = c + 1;
    end
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_pixel <= 1'b0;
      pix_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        scan_pixel(in_pixel);
        pixels_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pix_gap != 0) begin
          pix_gap <= pix_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          in_valid <= 1'b1;
          in_pixel <= pending_pixels.pop_front();
          pix_gap <= $urandom_range(0, pix_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // verdict monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_ok.size() == 0) begin
          $display("%0t: unexpected transaction, actual ok=%0b", $time, out_ok);
          errors++;
        end else begin
          want_ok = expected_ok.pop_front();
          results_seen++;
          if (out_ok !== want_ok) begin
            $display("%0t: ok mismatch, expected %0b, actual %0b", $time, want_ok, out_ok);
            errors++;
          end
        end
      end
      if (holds_served != holds_asked) begin
        holds_served <= holds_asked;
        stall_left <= 400;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready) begin
        stall_left <= $urandom_range(0, ok_stall_max);
        out_ready <= 1'b0;
      end else if (out_ready && ok_stall_max != 0 && $urandom_range(0, 15) == 0) begin
        stall_left <= $urandom_range(1, ok_stall_max);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic drain();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || in_valid || expected_ok.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << REG_SEL_BIT;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  cfg_width = value[WIDTH_W-1:0];
      REG_IMAGE_HEIGHT: cfg_height = value[HEIGHT_W-1:0];
      default: ;
    endcase
    restart_frame_model();
    reg_writes++;
  endtask

  task automatic set_geometry(input bit do_w, input int unsigned w,
                              input bit do_h, input int unsigned h);
    drain();
    if (do_w) reg_write(REG_IMAGE_WIDTH, w);
    if (do_h) reg_write(REG_IMAGE_HEIGHT, h);
    @(negedge clk);
  endtask

  task automatic push_bits(input logic [7:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) pending_pixels.push_back(bits[i]);
    queued += n;
  endtask

  task automatic queue_frame(input bit whole);
    int  w, h, n, dens, mode, cnt, k;
    bit  nb;
    bit  img[];
    w = span_cols();
    h = span_rows();
    n = w * h;
    img = new[n];
    dens = $urandom_range(0, 100);
    foreach (img[i]) img[i] = ($urandom_range(0, 99) < dens);
    mode = $urandom_range(0, 9);
    if (mode < 5) begin
      // drop isolated pixels, which leaves every other pixel's status intact
      for (int r = 0; r < h; r++) begin
        for (int c = 0; c < w; c++) begin
          k = r * w + c;
          nb = (r > 0 && img[k-w]) || (r + 1 < h && img[k+w]) ||
               (c > 0 && img[k-1]) || (c + 1 < w && img[k+1]);
          if (img[k] && !nb) img[k] = 1'b0;
        end
      end
      if (mode == 4) begin
        k = $urandom_range(0, n - 1);
        img[k] = !img[k];
      end
    end
    cnt = (whole || n == 1) ? n : $urandom_range(1, n - 1);
    for (int i = 0; i < cnt; i++) pending_pixels.push_back(img[i]);
    queued += cnt;
  endtask

  initial begin
    int unsigned w, h, kind, sel, nfr, phase, random_start;
    cfg_width = WIDTH_RST;
    cfg_height = HEIGHT_RST;
    restart_frame_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset geometry: run past the first full row, then cut short
    for (int i = 0; i < 1100; i++) pending_pixels.push_back(1'($urandom_range(0, 1)));
    queued += 1100;

    // zero sizes act as one pixel
    set_geometry(1'b1, 0, 1'b1, 0);
    pix_gap_max = 14;
    ok_stall_max = 14;
    push_bits(8'b10, 2);
    // single column
    set_geometry(1'b1, 1, 1'b1, 3);
    push_bits(8'b110, 3);
    push_bits(8'b101, 3);
    // single row
    set_geometry(1'b1, 3, 1'b1, 1);
    push_bits(8'b011, 3);
    push_bits(8'b101, 3);
    // diagonal pair against adjacent pair
    set_geometry(1'b1, 2, 1'b1, 2);
    push_bits(8'b1001, 4);
    push_bits(8'b1100, 4);

    phase = 0;
    random_start = queued;
    while (queued - random_start < 500) begin
      phase++;
      if (phase % 25 == 1) begin
        // hold the receiver while frames keep coming, so in_ready drops
        set_geometry(1'b1, $urandom_range(1, 4), 1'b1, $urandom_range(1, 4));
        pix_gap_max = 0;
        ok_stall_max = 0;
        holds_asked = holds_asked + 1;
        nfr = 6;
      end else begin
        kind = $urandom_range(0, 19);
        case (kind)
          0:       begin w = 0;                     h = $urandom_range(1, 8);  end
          1:       begin w = $urandom_range(1, 8);  h = 0;                     end
          2:       begin w = $urandom_range(9, 64); h = $urandom_range(1, 3);  end
          3:       begin w = $urandom_range(1, 3);  h = $urandom_range(9, 40); end
          default: begin w = $urandom_range(1, 8);  h = $urandom_range(1, 8);  end
        endcase
        sel = $urandom_range(0, 3);
        set_geometry(sel != 1, w, sel != 0, h);
        pix_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
        ok_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
        nfr = $urandom_range(1, 6);
      end
      for (int i = 0; i < nfr; i++) queue_frame(1'b1);
      if ($urandom_range(0, 3) == 0) queue_frame(1'b0);
    end

    // largest width, clamped by the block
    set_geometry(1'b1, 2047, 1'b1, 1);
    pix_gap_max = 3;
    ok_stall_max = 14;
    queue_frame(1'b1);
    drain();

    $display("Covered %0d pixels and %0d frames (%0d with an isolated pixel), %0d register writes.",
             pixels_sent, frames_done, bad_frames, reg_writes);
    $display("Compared %0d verdicts, %0d errors.", results_seen, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
